@@ hdl/btpc_pkg.sv @@
// Shared widths and types for the barometric compensation pipeline.
package btpc_pkg;

  // Magnitude width of the temperature divider (mc * 2048 over x1 + md).
  localparam int unsigned TDIV_W = 27;
  // Width of the pressure divider (b7 over b4).
  localparam int unsigned PDIV_W = 32;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CAL_A = 2'd0,
    CFG_CAL_B = 2'd1,
    CFG_CAL_C = 2'd2,
    CFG_OSS   = 2'd3
  } cfg_idx_t;

  // Fixed constants of the compensation formula.
  localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
  localparam logic [31:0]        B7_SCALE   = 32'd50000;
  localparam logic signed [31:0] P_COEF_SQ  = 32'sd3038;
  localparam logic signed [31:0] P_COEF_LIN = -32'sd7357;
  localparam logic signed [31:0] P_OFFSET   = 32'sd3791;
  localparam logic signed [31:0] P_MAX      = 32'sd262143;
  localparam logic signed [31:0] T_MAX      = 32'sd32767;
  localparam logic signed [31:0] T_MIN      = -32'sd32768;

  // Side data carried through the temperature divider.
  typedef struct packed {
    logic signed [16:0] x1;
    logic [23:0]        up;
    logic               neg;
    logic               err;
  } tdiv_side_t;

  // Side data carried through the pressure divider.
  typedef struct packed {
    logic signed [15:0] t;
    logic               err;
    logic               dbl;
  } pdiv_side_t;

endpackage

@@ hdl/baro_temp_pressure_compensation_unit.sv @@
// Top level of the barometric temperature and pressure compensation pipeline.
//
// Input channel in_*: one transfer carries a raw temperature word and a raw
// 24-bit pressure word. Result channel out_*: one transfer per input item with
// the temperature in 0.1 degC, the pressure in Pa and a divide error flag.
// The configuration port writes the packed calibration words and the
// oversampling setting; writes take effect at once. The user must make
// writes only while idle; the block itself does not enforce this.
//
// Throughput is one item per cycle while the receiver does not stall. An
// item passes input and setup stages, a 27-stage temperature divider, seven
// multiply stages, a 32-stage pressure divider and three final stages. Both
// dividers resolve one quotient bit per stage, which sets the depth.
//
// Reset clears all valid bits and the calibration registers. When the
// receiver stalls with a result waiting, the whole pipeline holds and
// in_tready drops; nothing is lost or repeated.
module baro_temp_pressure_compensation_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] raw_temperature, [39:16] raw_pressure
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] temperature_tenths, [33:16] pressure_pa, [34] divide_error
  output logic [39:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import btpc_pkg::*;

  // Configuration registers.
  logic [63:0] cal_a_r, cal_b_r;
  logic [31:0] cal_c_r;
  logic [1:0]  oss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_a_r <= '0;
      cal_b_r <= '0;
      cal_c_r <= '0;
      oss_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAL_A: cal_a_r <= cfg_wdata;
        CFG_CAL_B: cal_b_r <= cfg_wdata;
        CFG_CAL_C: cal_c_r <= cfg_wdata[31:0];
        CFG_OSS:   oss_r   <= cfg_wdata[1:0];
        default:   ;
      endcase
    end
  end

  // Calibration fields, sign- or zero-extended to 32 bits; mc and md stay 16-bit signed.
  logic signed [31:0] ac1, ac2, ac3, b1, b2;
  logic [31:0]        ac4, ac5, ac6;
  logic signed [15:0] mc, md;
  assign ac1 = 32'($signed(cal_a_r[15:0]));
  assign ac2 = 32'($signed(cal_a_r[31:16]));
  assign ac3 = 32'($signed(cal_a_r[47:32]));
  assign ac4 = 32'(cal_a_r[63:48]);
  assign ac5 = 32'(cal_b_r[15:0]);
  assign ac6 = 32'(cal_b_r[31:16]);
  assign b1  = 32'($signed(cal_b_r[47:32]));
  assign b2  = 32'($signed(cal_b_r[63:48]));
  assign mc  = $signed(cal_c_r[15:0]);
  assign md  = $signed(cal_c_r[31:16]);

  // The whole pipeline moves when the output register can take a result.
  logic adv;
  logic out_valid_r;
  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;

  // Stage 1: temperature product and oversampling shift of raw pressure.
  logic        v1_r;
  logic [31:0] tp_r;
  logic [23:0] up1_r;
  logic [31:0] tp_nxt;
  assign tp_nxt = (32'(in_tdata[15:0]) - ac6) * ac5;

  always_ff @(posedge clk) begin
    if (adv) begin
      tp_r  <= tp_nxt;
      up1_r <= in_tdata[39:16] >> (4'd8 - {2'b00, oss_r});
    end
  end

  // Stage 2: divider operands for mc * 2048 / (x1 + md).
  logic               v2_r;
  logic [TDIV_W-1:0]  tnum_r, tden_r;
  tdiv_side_t         ts2_r;
  logic signed [16:0] x1_s2;
  logic signed [17:0] x2d_s2;
  logic signed [26:0] num_s2;
  assign x1_s2  = $signed(tp_r[31:15]);
  assign x2d_s2 = 18'(x1_s2) + 18'(md);
  assign num_s2 = {mc, 11'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      tnum_r     <= mc[15] ? TDIV_W'(-num_s2) : TDIV_W'(num_s2);
      tden_r     <= TDIV_W'(x2d_s2[17] ? 18'(-x2d_s2) : x2d_s2);
      ts2_r.x1   <= x1_s2;
      ts2_r.up   <= up1_r;
      ts2_r.neg  <= mc[15] ^ x2d_s2[17];
      ts2_r.err  <= (x2d_s2 == 18'sd0);
    end
  end

  // Temperature divider.
  logic              td_valid;
  logic [TDIV_W-1:0] td_quo;
  logic [$bits(tdiv_side_t)-1:0] td_side_raw;
  tdiv_side_t        td_side;

  btpc_div #(.W(TDIV_W), .SW($bits(tdiv_side_t))) u_tdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v2_r),
    .dividend  (tnum_r),
    .divisor   (tden_r),
    .side_in   (ts2_r),
    .out_valid (td_valid),
    .quotient  (td_quo),
    .side_out  (td_side_raw)
  );
  assign td_side = tdiv_side_t'(td_side_raw);

  // Stage 3: b5, saturated temperature and b6.
  logic               v3_r;
  logic signed [31:0] b6_r;
  logic signed [15:0] t3_r;
  logic               err3_r;
  logic [23:0]        up3_r;
  logic signed [31:0] q_s3, b5_s3, t_s3;
  assign q_s3  = td_side.neg ? -32'(td_quo) : 32'(td_quo);
  assign b5_s3 = 32'(td_side.x1) + q_s3;
  assign t_s3  = (b5_s3 + 32'sd8) >>> 4;

  always_ff @(posedge clk) begin
    if (adv) begin
      b6_r   <= b5_s3 - B6_OFFSET;
      err3_r <= td_side.err;
      up3_r  <= td_side.up;
      if (t_s3 > T_MAX) begin
        t3_r <= 16'sh7fff;
      end else if (t_s3 < T_MIN) begin
        t3_r <= 16'sh8000;
      end else begin
        t3_r <= t_s3[15:0];
      end
    end
  end

  // Stage 4: b6 squared and the ac2, ac3 products.
  logic        v4_r;
  logic [31:0] sq4_r, m2_r, m3_r;
  logic signed [15:0] t4_r;
  logic        err4_r;
  logic [23:0] up4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq4_r  <= b6_r * b6_r;
      m2_r   <= ac2 * b6_r;
      m3_r   <= ac3 * b6_r;
      t4_r   <= t3_r;
      err4_r <= err3_r;
      up4_r  <= up3_r;
    end
  end

  // Stage 5: scale the products down.
  logic               v5_r;
  logic signed [31:0] b66_r, x2a_r, x1c_r;
  logic signed [15:0] t5_r;
  logic               err5_r;
  logic [23:0]        up5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      b66_r  <= 32'($signed(sq4_r[31:12]));
      x2a_r  <= 32'($signed(m2_r[31:11]));
      x1c_r  <= 32'($signed(m3_r[31:13]));
      t5_r   <= t4_r;
      err5_r <= err4_r;
      up5_r  <= up4_r;
    end
  end

  // Stage 6: b2 and b1 products with b66.
  logic               v6_r;
  logic [31:0]        p1_r, p2_r;
  logic signed [31:0] x2a6_r, x1c6_r;
  logic signed [15:0] t6_r;
  logic               err6_r;
  logic [23:0]        up6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r   <= b2 * b66_r;
      p2_r   <= b1 * b66_r;
      x2a6_r <= x2a_r;
      x1c6_r <= x1c_r;
      t6_r   <= t5_r;
      err6_r <= err5_r;
      up6_r  <= up5_r;
    end
  end

  // Stage 7: b3 and the b4 multiplicand.
  logic               v7_r;
  logic signed [31:0] b3_r;
  logic [31:0]        s7_r;
  logic signed [15:0] t7_r;
  logic               err7_r;
  logic [23:0]        up7_r;
  logic signed [31:0] x3_s7, v_s7, vs_s7, x3b_s7;
  assign x3_s7  = 32'($signed(p1_r[31:11])) + x2a6_r;
  assign v_s7   = (ac1 <<< 2) + x3_s7;
  assign vs_s7  = v_s7 <<< oss_r;
  assign x3b_s7 = (x1c6_r + 32'($signed(p2_r[31:16])) + 32'sd2) >>> 2;

  always_ff @(posedge clk) begin
    if (adv) begin
      b3_r   <= (vs_s7 + 32'sd2) >>> 2;
      s7_r   <= x3b_s7 + 32'sd32768;
      t7_r   <= t6_r;
      err7_r <= err6_r;
      up7_r  <= up6_r;
    end
  end

  // Stage 8: b4 and b7.
  logic               v8_r;
  logic [16:0]        b4_r;
  logic [31:0]        b7_r;
  logic signed [15:0] t8_r;
  logic               err8_r;
  logic [31:0]        b4p_s8, d_s8;
  assign b4p_s8 = ac4 * s7_r;
  assign d_s8   = 32'(up7_r) - b3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      b4_r   <= b4p_s8[31:15];
      b7_r   <= d_s8 * (B7_SCALE >> oss_r);
      t8_r   <= t7_r;
      err8_r <= err7_r;
    end
  end

  // Stage 9: pressure divider operands.
  logic              v9_r;
  logic [PDIV_W-1:0] pnum_r, pden_r;
  pdiv_side_t        ps9_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pnum_r    <= b7_r[31] ? b7_r : {b7_r[30:0], 1'b0};
      pden_r    <= PDIV_W'(b4_r);
      ps9_r.t   <= t8_r;
      ps9_r.err <= err8_r || (b4_r == 17'd0);
      ps9_r.dbl <= b7_r[31];
    end
  end

  // Pressure divider.
  logic              pd_valid;
  logic [PDIV_W-1:0] pd_quo;
  logic [$bits(pdiv_side_t)-1:0] pd_side_raw;
  pdiv_side_t        pd_side;

  btpc_div #(.W(PDIV_W), .SW($bits(pdiv_side_t))) u_pdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v9_r),
    .dividend  (pnum_r),
    .divisor   (pden_r),
    .side_in   (ps9_r),
    .out_valid (pd_valid),
    .quotient  (pd_quo),
    .side_out  (pd_side_raw)
  );
  assign pd_side = pdiv_side_t'(pd_side_raw);

  // Stage 10: raw pressure p and the first correction products.
  logic               v10_r;
  logic signed [31:0] p10_r;
  logic [31:0]        sq10_r, ml10_r;
  pdiv_side_t         ps10_r;
  logic signed [31:0] p_s10, x1_s10;
  assign p_s10  = pd_side.dbl ? $signed({pd_quo[30:0], 1'b0}) : $signed(pd_quo);
  assign x1_s10 = p_s10 >>> 8;

  always_ff @(posedge clk) begin
    if (adv) begin
      p10_r  <= p_s10;
      sq10_r <= x1_s10 * x1_s10;
      ml10_r <= P_COEF_LIN * p_s10;
      ps10_r <= pd_side;
    end
  end

  // Stage 11: square term scaled by its coefficient.
  logic               v11_r;
  logic signed [31:0] p11_r, x2_11_r;
  logic [31:0]        r11_r;
  pdiv_side_t         ps11_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p11_r   <= p10_r;
      r11_r   <= sq10_r * P_COEF_SQ;
      x2_11_r <= 32'($signed(ml10_r[31:16]));
      ps11_r  <= ps10_r;
    end
  end

  // Stage 12: final pressure, saturation and the output register.
  logic signed [31:0] pf_s12;
  logic [17:0]        psat_s12;
  assign pf_s12 = p11_r
                + ((32'($signed(r11_r[31:16])) + x2_11_r + P_OFFSET) >>> 4);

  always_comb begin
    if (pf_s12 < 32'sd0) begin
      psat_s12 = '0;
    end else if (pf_s12 > P_MAX) begin
      psat_s12 = '1;
    end else begin
      psat_s12 = pf_s12[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata[15:0]  <= ps11_r.err ? 16'd0 : ps11_r.t;
      out_tdata[33:16] <= ps11_r.err ? 18'd0 : psat_s12;
      out_tdata[34]    <= ps11_r.err;
      out_tdata[39:35] <= '0;
    end
  end

  // Valid bits of the stages outside the dividers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      v9_r        <= 1'b0;
      v10_r       <= 1'b0;
      v11_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_tvalid;
      v2_r        <= v1_r;
      v3_r        <= td_valid;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      v8_r        <= v7_r;
      v9_r        <= v8_r;
      v10_r       <= pd_valid;
      v11_r       <= v10_r;
      out_valid_r <= v11_r;
    end
  end

endmodule

@@ hdl/btpc_div.sv @@
// Pipelined restoring unsigned divider, one quotient bit per stage.
module btpc_div #(
  parameter int unsigned W  = 32,
  parameter int unsigned SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  dividend,
  input  logic [W-1:0]  divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [W-1:0]  quotient,
  output logic [SW-1:0] side_out
);

  logic [W-1:0]  rem_r  [W];
  logic [W-1:0]  dq_r   [W];
  logic [W-1:0]  dv_r   [W];
  logic [SW-1:0] side_r [W];
  logic [W-1:0]  vld_r;

  logic [W-1:0]  rem_src [W];
  logic [W-1:0]  dq_src  [W];
  logic [W-1:0]  dv_src  [W];
  logic [SW-1:0] side_src[W];
  logic [W-1:0]  rem_nxt [W];
  logic [W-1:0]  dq_nxt  [W];

  // Each stage shifts in one dividend bit and tries one subtraction.
  always_comb begin
    logic [W:0] trial;
    logic       ge;
    for (int s = 0; s < W; s++) begin
      if (s == 0) begin
        rem_src[s]  = '0;
        dq_src[s]   = dividend;
        dv_src[s]   = divisor;
        side_src[s] = side_in;
      end else begin
        rem_src[s]  = rem_r[s-1];
        dq_src[s]   = dq_r[s-1];
        dv_src[s]   = dv_r[s-1];
        side_src[s] = side_r[s-1];
      end
      trial = {rem_src[s], dq_src[s][W-1]};
      ge = (trial >= {1'b0, dv_src[s]});
      rem_nxt[s] = ge ? W'(trial - {1'b0, dv_src[s]}) : trial[W-1:0];
      dq_nxt[s] = {dq_src[s][W-2:0], ge};
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < W; s++) begin
        rem_r[s]  <= rem_nxt[s];
        dq_r[s]   <= dq_nxt[s];
        dv_r[s]   <= dv_src[s];
        side_r[s] <= side_src[s];
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[W-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[W-1];
  assign quotient  = dq_r[W-1];
  assign side_out  = side_r[W-1];

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the barometric temperature and pressure compensation unit.
module tb;
  import btpc_pkg::*;

  typedef struct packed {
    logic               err;
    logic [17:0]        pa;
    logic signed [15:0] tenths;
  } comp_result_t;

  typedef struct {
    logic [15:0] ut;
    logic [23:0] up;
    bit          known;
    comp_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wdata;

  // Shadow copy of the calibration registers.
  logic [63:0] cal_a, cal_b;
  logic [31:0] cal_c;
  logic [1:0]  oss_set;

  comp_result_t expected_q[$];
  int  fail_count;

  baro_temp_pressure_compensation_unit uut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint wrap32(longint v);
    return longint'(int'(v));
  endfunction

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // Integer compensation of one raw temperature and pressure pair.
  function automatic comp_result_t compensate(logic [15:0] ut_raw, logic [23:0] up_raw);
    comp_result_t r;
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut;
    longint x1, x2, x3, b3, b5, b6, b66, t, p;
    longint unsigned b4, b7, pu, up;
    r = '{err: 1'b1, pa: '0, tenths: '0};
    ac1 = longint'($signed(cal_a[15:0]));
    ac2 = longint'($signed(cal_a[31:16]));
    ac3 = longint'($signed(cal_a[47:32]));
    ac4 = longint'(cal_a[63:48]);
    ac5 = longint'(cal_b[15:0]);
    ac6 = longint'(cal_b[31:16]);
    b1  = longint'($signed(cal_b[47:32]));
    b2  = longint'($signed(cal_b[63:48]));
    mc  = longint'($signed(cal_c[15:0]));
    md  = longint'($signed(cal_c[31:16]));
    ut  = longint'(ut_raw);
    up  = longint'(up_raw) >> (8 - oss_set);

    // Temperature part.
    x1 = floor_shr(wrap32((ut - ac6) * ac5), 15);
    x2 = wrap32(x1 + md);
    if (x2 == 0) return r;
    x2 = (mc * 2048) / x2;
    b5 = wrap32(x1 + x2);
    t  = floor_shr(wrap32(b5 + 8), 4);

    // Pressure part.
    b6  = wrap32(b5 - B6_OFFSET);
    b66 = floor_shr(wrap32(b6 * b6), 12);
    x1  = floor_shr(wrap32(b2 * b66), 11);
    x2  = floor_shr(wrap32(ac2 * b6), 11);
    x3  = wrap32(x1 + x2);
    b3  = floor_shr(wrap32(wrap32(wrap32(ac1 * 4 + x3) << oss_set) + 2), 2);
    x1  = floor_shr(wrap32(ac3 * b6), 13);
    x2  = floor_shr(wrap32(b1 * b66), 16);
    x3  = floor_shr(wrap32(x1 + x2 + 2), 2);
    b4  = ((longint'(ac4) * (wrap32(x3 + 32768) & 64'hFFFF_FFFF)) & 64'hFFFF_FFFF) >> 15;
    if (b4 == 0) return r;
    b7 = (((up - b3) & 64'hFFFF_FFFF) * (B7_SCALE >> oss_set)) & 64'hFFFF_FFFF;
    if (b7 < 64'h8000_0000) pu = ((b7 * 2) & 64'hFFFF_FFFF) / b4;
    else pu = ((b7 / b4) * 2) & 64'hFFFF_FFFF;
    p  = wrap32(pu);
    x1 = floor_shr(p, 8);
    x1 = wrap32(x1 * x1);
    x1 = floor_shr(wrap32(x1 * P_COEF_SQ), 16);
    x2 = floor_shr(wrap32(P_COEF_LIN * p), 16);
    p  = wrap32(p + floor_shr(wrap32(x1 + x2 + P_OFFSET), 4));

    if (t > T_MAX) t = T_MAX;
    if (t < T_MIN) t = T_MIN;
    if (p < 0) p = 0;
    if (p > P_MAX) p = P_MAX;
    r.err = 1'b0;
    r.tenths = t[15:0];
    r.pa = p[17:0];
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_CAL_A: cal_a = value;
      CFG_CAL_B: cal_b = value;
      CFG_CAL_C: cal_c = value[31:0];
      CFG_OSS:   oss_set = value[1:0];
    endcase
  endtask

  // Send one pair; a known row overrides the predicted result.
  task automatic send_pair(stim_row_t row, bit no_gap);
    int gap;
    comp_result_t exp_res;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {row.up, row.ut};
    exp_res = row.known ? row.res : compensate(row.ut, row.up);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(exp_res);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // Typical factory calibration set.
  localparam logic [63:0] TYP_A = {16'd32741, 16'hC7A9, 16'hFB9E, 16'd408};
  localparam logic [63:0] TYP_B = {16'd4, 16'd6190, 16'd23153, 16'd32757};
  localparam logic [31:0] TYP_C = {16'd2868, 16'hD4BD};

  stim_row_t table_rows[$];

  // Output side: random stalls and checking.
  initial begin
    comp_result_t got, want;
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = comp_result_t'(out_tdata[34:0]);
        if (expected_q.size() == 0) begin
          $error("result transfer with no expectation: %h", out_tdata);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.tenths !== want.tenths) begin
            $error("temperature_tenths expected %0d got %0d", want.tenths, got.tenths);
            fail_count++;
          end
          if (got.pa !== want.pa) begin
            $error("pressure_pa expected %0d got %0d", want.pa, got.pa);
            fail_count++;
          end
          if (got.err !== want.err) begin
            $error("divide_error expected %0b got %0b", want.err, got.err);
            fail_count++;
          end
        end
      end
    end
  end

  // Stimulus.
  initial begin
    stim_row_t row;
    comp_result_t zero_err;
    int n;
    fail_count = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_CAL_A;
    cfg_wdata = '0;
    cal_a = '0; cal_b = '0; cal_c = '0; oss_set = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    zero_err = '{err: 1'b1, pa: '0, tenths: '0};

    // After reset all calibration is zero, so the temperature divisor is zero.
    table_rows.push_back('{16'h0000, 24'h000000, 1'b1, zero_err});
    table_rows.push_back('{16'hFFFF, 24'hFFFFFF, 1'b1, zero_err});
    foreach (table_rows[i]) send_pair(table_rows[i], 1'b0);
    drain();

    // Typical calibration, field extremes and each oversampling mode.
    write_reg(CFG_CAL_A, TYP_A);
    write_reg(CFG_CAL_B, TYP_B);
    write_reg(CFG_CAL_C, TYP_C);
    for (int o = 0; o < 4; o++) begin
      write_reg(CFG_OSS, 64'(o));
      table_rows.delete();
      table_rows.push_back('{16'd27898, 24'h5D2300, 1'b0, zero_err});
      table_rows.push_back('{16'h0000, 24'h000000, 1'b0, zero_err});
      table_rows.push_back('{16'hFFFF, 24'hFFFFFF, 1'b0, zero_err});
      table_rows.push_back('{16'h0000, 24'hFFFFFF, 1'b0, zero_err});
      table_rows.push_back('{16'hFFFF, 24'h000000, 1'b0, zero_err});
      foreach (table_rows[i]) send_pair(table_rows[i], o[0]);
      drain();
    end

    // Zero pressure divisor: AC4 zero gives B4 zero.
    write_reg(CFG_CAL_A, {16'd0, TYP_A[47:0]});
    row = '{16'd27898, 24'h5D2300, 1'b1, zero_err};
    send_pair(row, 1'b0);
    drain();

    // Random calibration phases with mostly realistic and some random words.
    for (int ph = 0; ph < 16; ph++) begin
      if (ph == 15) begin
        write_reg(CFG_CAL_A, '1);
        write_reg(CFG_CAL_B, '1);
        write_reg(CFG_CAL_C, 64'hFFFF_FFFF);
      end else if (ph % 4 == 3) begin
        write_reg(CFG_CAL_A, {$urandom, $urandom});
        write_reg(CFG_CAL_B, {$urandom, $urandom});
        write_reg(CFG_CAL_C, 64'($urandom));
      end else begin
        write_reg(CFG_CAL_A, TYP_A ^ 64'($urandom_range(0, 255)));
        write_reg(CFG_CAL_B, TYP_B ^ {16'd0, 16'($urandom_range(0, 63)), 32'd0});
        write_reg(CFG_CAL_C, TYP_C ^ 32'($urandom_range(0, 127)));
      end
      write_reg(CFG_OSS, 64'($urandom_range(0, 3)));
      n = 90;
      for (int k = 0; k < n; k++) begin
        row.known = 1'b0;
        if ($urandom_range(0, 3) != 0) begin
          row.ut = 16'($urandom_range(20000, 36000));
          row.up = 24'($urandom_range(24'h400000, 24'hB00000));
        end else begin
          row.ut = 16'($urandom);
          row.up = 24'($urandom);
        end
        send_pair(row, ($urandom_range(0, 4) == 0));
      end
      drain();
    end

    if (fail_count == 0)
      $display("baro_temp_pressure_compensation_unit regression: pass");
    else
      $display("baro_temp_pressure_compensation_unit regression: fail");
    $finish;
  end

  // Timeout guard.
  initial begin
    #3000000;
    $display("baro_temp_pressure_compensation_unit regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
hdl/btpc_pkg.sv
hdl/btpc_div.sv
hdl/baro_temp_pressure_compensation_unit.sv
verif/tb.sv
